@@ rtl/cor_pkg.sv @@
package cor_pkg;

    // Configuration register widths
    localparam int STRIDE_BITS = 15;
    localparam int DIM_BITS    = 13;
    localparam int PIX_BITS    = 8;
    localparam int RAD_IN_BITS = 7;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;

    // Parameter defaults
    localparam int DEF_MAX_RADIUS      = 64;
    localparam int DEF_COORD_BITS      = 12;
    localparam int DEF_ADDR_BITS       = 24;
    localparam int DEF_BYTES_PER_PIXEL = 4;

    // Result count cap per request
    localparam int RESULT_CAP = 64;
    localparam int CNT_BITS   = $clog2(RESULT_CAP);

    // Reset values of the configuration registers
    localparam logic [STRIDE_BITS-1:0] RST_LINE_STRIDE  = 15'd1600;
    localparam logic [DIM_BITS-1:0]    RST_IMAGE_WIDTH  = 13'd400;
    localparam logic [DIM_BITS-1:0]    RST_IMAGE_HEIGHT = 13'd300;
    localparam logic [PIX_BITS-1:0]    RST_PIXEL_VALUE  = 8'd255;

    // Register indexes
    typedef enum logic [1:0] {
        REG_LINE_STRIDE  = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2,
        REG_PIXEL_VALUE  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [STRIDE_BITS-1:0] line_stride;
        logic [DIM_BITS-1:0]    image_width;
        logic [DIM_BITS-1:0]    image_height;
        logic [PIX_BITS-1:0]    pixel_value;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_C,
        ST_MUL_R,
        ST_RUN
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mul_c;
        logic mul_r;
        logic emit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic rad_zero;
        logic last;
    } status_t;

endpackage

@@ rtl/cor_cfg_regs.sv @@
module cor_cfg_regs
    import cor_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output cfg_t                     cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Write a register on the access beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_stride  <= RST_LINE_STRIDE;
            cfg_reg.image_width  <= RST_IMAGE_WIDTH;
            cfg_reg.image_height <= RST_IMAGE_HEIGHT;
            cfg_reg.pixel_value  <= RST_PIXEL_VALUE;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_LINE_STRIDE:  cfg_reg.line_stride  <= pwdata[STRIDE_BITS-1:0];
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= pwdata[DIM_BITS-1:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= pwdata[DIM_BITS-1:0];
                REG_PIXEL_VALUE:  cfg_reg.pixel_value  <= pwdata[PIX_BITS-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            REG_LINE_STRIDE:  prdata = APB_DATA_BITS'(cfg_reg.line_stride);
            REG_IMAGE_WIDTH:  prdata = APB_DATA_BITS'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_BITS'(cfg_reg.image_height);
            REG_PIXEL_VALUE:  prdata = APB_DATA_BITS'(cfg_reg.pixel_value);
            default:          prdata = '0;
        endcase
    end

endmodule

@@ rtl/cor_ctrl.sv @@
module cor_ctrl
    import cor_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_MUL_C;
            end
            ST_MUL_C:
            begin
                if (status.rad_zero)
                    state_next = ST_IDLE;
                else
                    state_next = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (slot_free && status.last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and commands
    always_comb
    begin
        in_ready  = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MUL_C: cmd.mul_c = 1'b1;
            ST_MUL_R: cmd.mul_r = 1'b1;
            ST_RUN:   cmd.emit  = slot_free;
            default:  cmd = '0;
        endcase
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

endmodule

@@ rtl/cor_datapath.sv @@
module cor_datapath
    import cor_pkg::*;
#(
    parameter int MAX_RADIUS      = DEF_MAX_RADIUS,
    parameter int COORD_BITS      = DEF_COORD_BITS,
    parameter int ADDR_BITS       = DEF_ADDR_BITS,
    parameter int BYTES_PER_PIXEL = DEF_BYTES_PER_PIXEL
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output status_t                status,
    input  cfg_t                   cfg,
    input  logic [COORD_BITS-1:0]  center_x,
    input  logic [COORD_BITS-1:0]  center_y,
    input  logic [RAD_IN_BITS-1:0] radius,
    output logic [ADDR_BITS-1:0]   addr_px_py,
    output logic [ADDR_BITS-1:0]   addr_py_px,
    output logic [ADDR_BITS-1:0]   addr_ny_px,
    output logic [ADDR_BITS-1:0]   addr_nx_py,
    output logic [ADDR_BITS-1:0]   addr_nx_ny,
    output logic [ADDR_BITS-1:0]   addr_ny_nx,
    output logic [ADDR_BITS-1:0]   addr_py_nx,
    output logic [ADDR_BITS-1:0]   addr_px_ny,
    output logic [7:0]             outside_mask,
    output logic [PIX_BITS-1:0]    pixel_byte,
    output logic                   last_step
);

    localparam int RB  = $clog2(MAX_RADIUS + 1);       // radius bits
    localparam int XB  = RB + 1;                        // signed loop coordinate
    localparam int DB  = RB + 2;                        // delta bits
    localparam int EB  = RB + 3;                        // signed error bits
    localparam int PW  = COORD_BITS + 2;                // signed point coordinate
    localparam int CB  = (PW > DIM_BITS + 1) ? PW : DIM_BITS + 1;
    localparam int PRB = COORD_BITS + STRIDE_BITS;

    // Held request
    logic [COORD_BITS-1:0] cx_reg, cy_reg;
    logic [RB-1:0]         rad_reg;
    logic [RB-1:0]         rad_sat;

    // Loop state
    logic signed [XB-1:0] x_reg, y_reg;
    logic signed [EB-1:0] err_reg;
    logic [DB-1:0]        dx_reg, dy_reg;
    logic [CNT_BITS-1:0]  cnt_reg;

    // Row base addresses, modulo the address width
    logic [ADDR_BITS-1:0] cys_reg;
    logic [ADDR_BITS-1:0] row_py_reg, row_ny_reg, row_px_reg, row_nx_reg;

    // Result register
    logic [ADDR_BITS-1:0] addr_reg [8];
    logic [7:0]           mask_reg;
    logic [PIX_BITS-1:0]  pix_reg;
    logic                 last_reg;

    // Shared setup multiplier
    logic [COORD_BITS-1:0] mul_a;
    logic [PRB-1:0]        prod;
    logic [ADDR_BITS-1:0]  prod_a, stride_a;

    // Loop step
    logic                 y_step, x_step;
    logic signed [EB-1:0] err_mid, err_next;
    logic signed [XB-1:0] x_next, y_next;
    logic [DB-1:0]        dx_next, dy_next;
    logic signed [EB-1:0] two_r;

    // Points
    logic signed [PW-1:0]  cx_s, cy_s, x_s, y_s;
    logic signed [PW-1:0]  col_px, col_nx, col_py, col_ny;
    logic signed [PW-1:0]  row_py, row_ny, row_px, row_nx;
    logic signed [PW-1:0]  pcol [8];
    logic signed [PW-1:0]  prow [8];
    logic [ADDR_BITS-1:0]  pbase [8];
    logic [ADDR_BITS-1:0]  paddr_c [8];
    logic [7:0]            pmask;
    logic signed [CB-1:0]  w_s, h_s;

    // Saturate the radius
    always_comb
    begin
        if (radius > RAD_IN_BITS'(MAX_RADIUS))
            rad_sat = RB'(MAX_RADIUS);
        else
            rad_sat = RB'(radius);
    end

    assign mul_a    = cmd.mul_c ? cy_reg : COORD_BITS'(rad_reg);
    assign prod     = PRB'(mul_a) * PRB'(cfg.line_stride);
    assign prod_a   = ADDR_BITS'(prod);
    assign stride_a = ADDR_BITS'(cfg.line_stride);

    // One midpoint iteration
    assign two_r = $signed({2'b00, rad_reg, 1'b0});
    always_comb
    begin
        y_step  = (err_reg <= 0);
        err_mid = err_reg;
        y_next  = y_reg;
        dy_next = dy_reg;
        if (y_step)
        begin
            y_next  = y_reg + XB'(1);
            err_mid = err_reg + $signed({1'b0, dy_reg});
            dy_next = dy_reg + DB'(2);
        end
        x_step   = (err_mid > 0);
        err_next = err_mid;
        x_next   = x_reg;
        dx_next  = dx_reg;
        if (x_step)
        begin
            x_next   = x_reg - XB'(1);
            dx_next  = dx_reg + DB'(2);
            err_next = err_mid + $signed({1'b0, dx_next}) - two_r;
        end
    end

    assign status.rad_zero = (rad_reg == '0);
    assign status.last     = (x_next < y_next) || (cnt_reg == CNT_BITS'(RESULT_CAP - 1));

    // Eight symmetric points
    assign cx_s = $signed({2'b00, cx_reg});
    assign cy_s = $signed({2'b00, cy_reg});
    assign x_s  = PW'(x_reg);
    assign y_s  = PW'(y_reg);
    assign col_px = cx_s + x_s;
    assign col_nx = cx_s - x_s;
    assign col_py = cx_s + y_s;
    assign col_ny = cx_s - y_s;
    assign row_py = cy_s + y_s;
    assign row_ny = cy_s - y_s;
    assign row_px = cy_s + x_s;
    assign row_nx = cy_s - x_s;
    assign w_s = CB'($signed({1'b0, cfg.image_width}));
    assign h_s = CB'($signed({1'b0, cfg.image_height}));

    always_comb
    begin
        pcol[0] = col_px; prow[0] = row_py; pbase[0] = row_py_reg;
        pcol[1] = col_py; prow[1] = row_px; pbase[1] = row_px_reg;
        pcol[2] = col_ny; prow[2] = row_px; pbase[2] = row_px_reg;
        pcol[3] = col_nx; prow[3] = row_py; pbase[3] = row_py_reg;
        pcol[4] = col_nx; prow[4] = row_ny; pbase[4] = row_ny_reg;
        pcol[5] = col_ny; prow[5] = row_nx; pbase[5] = row_nx_reg;
        pcol[6] = col_py; prow[6] = row_nx; pbase[6] = row_nx_reg;
        pcol[7] = col_px; prow[7] = row_ny; pbase[7] = row_ny_reg;
        for (int k = 0; k < 8; k++)
        begin
            pmask[k] = (pcol[k] < 0) || (prow[k] < 0) ||
                       (CB'(pcol[k]) >= w_s) || (CB'(prow[k]) >= h_s);
            if (pmask[k])
                paddr_c[k] = '0;
            else
                paddr_c[k] = ADDR_BITS'(pcol[k]) * ADDR_BITS'(BYTES_PER_PIXEL) + pbase[k];
        end
    end

    // Capture request, set up row bases, step the loop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.emit)
        begin
            cnt_reg <= cnt_reg + CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg  <= center_x;
            cy_reg  <= center_y;
            rad_reg <= rad_sat;
            x_reg   <= $signed({1'b0, rad_sat}) - XB'(1);
            y_reg   <= '0;
            dx_reg  <= DB'(1);
            dy_reg  <= DB'(1);
            err_reg <= EB'(1) - $signed({2'b00, rad_sat, 1'b0});
        end
        else if (cmd.mul_c)
        begin
            cys_reg    <= prod_a;
            row_py_reg <= prod_a;
            row_ny_reg <= prod_a;
        end
        else if (cmd.mul_r)
        begin
            row_px_reg <= cys_reg + prod_a - stride_a;
            row_nx_reg <= cys_reg - prod_a + stride_a;
        end
        else if (cmd.emit)
        begin
            for (int k = 0; k < 8; k++)
                addr_reg[k] <= paddr_c[k];
            mask_reg <= pmask;
            pix_reg  <= cfg.pixel_value;
            last_reg <= status.last;
            x_reg    <= x_next;
            y_reg    <= y_next;
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            err_reg  <= err_next;
            if (y_step)
            begin
                row_py_reg <= row_py_reg + stride_a;
                row_ny_reg <= row_ny_reg - stride_a;
            end
            if (x_step)
            begin
                row_px_reg <= row_px_reg - stride_a;
                row_nx_reg <= row_nx_reg + stride_a;
            end
        end
    end

    assign addr_px_py   = addr_reg[0];
    assign addr_py_px   = addr_reg[1];
    assign addr_ny_px   = addr_reg[2];
    assign addr_nx_py   = addr_reg[3];
    assign addr_nx_ny   = addr_reg[4];
    assign addr_ny_nx   = addr_reg[5];
    assign addr_py_nx   = addr_reg[6];
    assign addr_px_ny   = addr_reg[7];
    assign outside_mask = mask_reg;
    assign pixel_byte   = pix_reg;
    assign last_step    = last_reg;

endmodule

@@ rtl/circle_octant_rasterizer_top.sv @@
// Channel   Handshake              Payload
// input     in_valid / in_ready    center_x, center_y, radius
// output    out_valid / out_ready  addr_* (8), outside_mask, pixel_byte, last_step
// config    APB psel/penable       paddr, pwdata, prdata (pready tied high)
//
// A request is accepted in idle, then set up on the shared stride multiplier
// (center row, then radius), then stepped through the result loop; radius 64
// gives 46 results. A zero radius returns to idle with no results. Requests
// are taken only in idle. The loop advances only when the output register is
// free or being taken. Reset clears control and loads the register defaults.
module circle_octant_rasterizer_top
    import cor_pkg::*;
#(
    parameter int MAX_RADIUS      = DEF_MAX_RADIUS,
    parameter int COORD_BITS      = DEF_COORD_BITS,
    parameter int ADDR_BITS       = DEF_ADDR_BITS,
    parameter int BYTES_PER_PIXEL = DEF_BYTES_PER_PIXEL
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [COORD_BITS-1:0]    center_x,
    input  logic [COORD_BITS-1:0]    center_y,
    input  logic [RAD_IN_BITS-1:0]   radius,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [ADDR_BITS-1:0]     addr_px_py,
    output logic [ADDR_BITS-1:0]     addr_py_px,
    output logic [ADDR_BITS-1:0]     addr_ny_px,
    output logic [ADDR_BITS-1:0]     addr_nx_py,
    output logic [ADDR_BITS-1:0]     addr_nx_ny,
    output logic [ADDR_BITS-1:0]     addr_ny_nx,
    output logic [ADDR_BITS-1:0]     addr_py_nx,
    output logic [ADDR_BITS-1:0]     addr_px_ny,
    output logic [7:0]               outside_mask,
    output logic [PIX_BITS-1:0]      pixel_byte,
    output logic                     last_step
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    cor_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cor_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    cor_datapath #(
        .MAX_RADIUS      (MAX_RADIUS),
        .COORD_BITS      (COORD_BITS),
        .ADDR_BITS       (ADDR_BITS),
        .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg          (cfg),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius       (radius),
        .addr_px_py   (addr_px_py),
        .addr_py_px   (addr_py_px),
        .addr_ny_px   (addr_ny_px),
        .addr_nx_py   (addr_nx_py),
        .addr_nx_ny   (addr_nx_ny),
        .addr_ny_nx   (addr_ny_nx),
        .addr_py_nx   (addr_py_nx),
        .addr_px_ny   (addr_px_ny),
        .outside_mask (outside_mask),
        .pixel_byte   (pixel_byte),
        .last_step    (last_step)
    );

endmodule

@@ dv/octant_checker.sv @@
module octant_checker
    import cor_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic                      pready,
    input  logic [APB_ADDR_BITS-1:0]  paddr,
    input  logic [APB_DATA_BITS-1:0]  pwdata,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [DEF_COORD_BITS-1:0] center_x,
    input  logic [DEF_COORD_BITS-1:0] center_y,
    input  logic [RAD_IN_BITS-1:0]    radius,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [DEF_ADDR_BITS-1:0]  addr_px_py,
    input  logic [DEF_ADDR_BITS-1:0]  addr_py_px,
    input  logic [DEF_ADDR_BITS-1:0]  addr_ny_px,
    input  logic [DEF_ADDR_BITS-1:0]  addr_nx_py,
    input  logic [DEF_ADDR_BITS-1:0]  addr_nx_ny,
    input  logic [DEF_ADDR_BITS-1:0]  addr_ny_nx,
    input  logic [DEF_ADDR_BITS-1:0]  addr_py_nx,
    input  logic [DEF_ADDR_BITS-1:0]  addr_px_ny,
    input  logic [7:0]                outside_mask,
    input  logic [PIX_BITS-1:0]       pixel_byte,
    input  logic                      last_step,
    output int                        mismatches,
    output int                        results_left
);
    timeunit 1ns;
    timeprecision 1ps;

    // One output beat; point k follows the port order addr_px_py .. addr_px_ny
    typedef struct packed {
        logic [7:0][DEF_ADDR_BITS-1:0] addr;
        logic [7:0]                    outside;
        logic [PIX_BITS-1:0]           pix;
        logic                          last;
    } octant_beat_t;

    cfg_t         shadow;
    octant_beat_t octant_beats[$];
    octant_beat_t seen;
    octant_beat_t want;
    logic         beat_bad;

    // Run the midpoint loop for one request and queue every beat it produces
    function automatic void plot_circle(input int cx, input int cy, input int r_in);
        int          r;
        int          x;
        int          y;
        int          dx;
        int          dy;
        int          err;
        int          n;
        int          k;
        int          w;
        int          h;
        int          px [8];
        int          py [8];
        logic [31:0] byte_addr;
        octant_beat_t b;
        r = (r_in > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : r_in;
        w = shadow.image_width;
        h = shadow.image_height;
        x = r - 1;
        y = 0;
        dx = 1;
        dy = 1;
        err = dx - 2 * r;
        n = 0;
        while (x >= y && n < RESULT_CAP)
        begin
            px[0] = cx + x; py[0] = cy + y;
            px[1] = cx + y; py[1] = cy + x;
            px[2] = cx - y; py[2] = cy + x;
            px[3] = cx - x; py[3] = cy + y;
            px[4] = cx - x; py[4] = cy - y;
            px[5] = cx - y; py[5] = cy - x;
            px[6] = cx + y; py[6] = cy - x;
            px[7] = cx + x; py[7] = cy - y;
            b = '0;
            for (k = 0; k < 8; k++)
            begin
                // clipped points read zero and set their mask bit
                if (px[k] < 0 || py[k] < 0 || px[k] >= w || py[k] >= h)
                begin
                    b.outside[k] = 1'b1;
                end
                else
                begin
                    byte_addr = px[k] * DEF_BYTES_PER_PIXEL + py[k] * int'(shadow.line_stride);
                    b.addr[k] = byte_addr[DEF_ADDR_BITS-1:0];
                end
            end
            b.pix = shadow.pixel_value;
            n++;
            // advance the decision variables
            if (err <= 0)
            begin
                y++;
                err += dy;
                dy += 2;
            end
            if (err > 0)
            begin
                x--;
                dx += 2;
                err += dx - 2 * r;
            end
            b.last = !(x >= y && n < RESULT_CAP);
            octant_beats.push_back(b);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow.line_stride  = RST_LINE_STRIDE;
            shadow.image_width  = RST_IMAGE_WIDTH;
            shadow.image_height = RST_IMAGE_HEIGHT;
            shadow.pixel_value  = RST_PIXEL_VALUE;
            octant_beats.delete();
            mismatches   = 0;
            results_left <= 0;
        end
        else
        begin
            // track register writes
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_LINE_STRIDE:  shadow.line_stride  = pwdata[STRIDE_BITS-1:0];
                    REG_IMAGE_WIDTH:  shadow.image_width  = pwdata[DIM_BITS-1:0];
                    REG_IMAGE_HEIGHT: shadow.image_height = pwdata[DIM_BITS-1:0];
                    REG_PIXEL_VALUE:  shadow.pixel_value  = pwdata[PIX_BITS-1:0];
                    default: ;
                endcase
            end

            // predict the beats of each accepted request
            if (in_valid && in_ready)
            begin
                plot_circle(center_x, center_y, radius);
            end

            // compare each accepted result beat with the oldest prediction
            if (out_valid && out_ready)
            begin
                seen.addr = {addr_px_ny, addr_py_nx, addr_ny_nx, addr_nx_ny,
                             addr_nx_py, addr_ny_px, addr_py_px, addr_px_py};
                seen.outside = outside_mask;
                seen.pix     = pixel_byte;
                seen.last    = last_step;
                if (octant_beats.size() == 0)
                begin
                    $display("%0t: result beat with no circle pending, addr_px_py %0h",
                             $time, addr_px_py);
                    mismatches++;
                end
                else
                begin
                    want = octant_beats.pop_front();
                    beat_bad = 1'b0;
                    for (int k = 0; k < 8; k++)
                    begin
                        if (seen.addr[k] !== want.addr[k])
                        begin
                            $display("%0t: point %0d address expected %0h got %0h",
                                     $time, k, want.addr[k], seen.addr[k]);
                            beat_bad = 1'b1;
                        end
                    end
                    if (seen.outside !== want.outside)
                    begin
                        $display("%0t: outside_mask expected %0h got %0h",
                                 $time, want.outside, seen.outside);
                        beat_bad = 1'b1;
                    end
                    if (seen.pix !== want.pix)
                    begin
                        $display("%0t: pixel_byte expected %0h got %0h",
                                 $time, want.pix, seen.pix);
                        beat_bad = 1'b1;
                    end
                    if (seen.last !== want.last)
                    begin
                        $display("%0t: last_step expected %0b got %0b",
                                 $time, want.last, seen.last);
                        beat_bad = 1'b1;
                    end
                    if (beat_bad)
                    begin
                        mismatches++;
                    end
                end
            end
            results_left <= octant_beats.size();
        end
    end

endmodule

@@ dv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cor_pkg::*;

    logic                      clk;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_BITS-1:0]  paddr;
    logic [APB_DATA_BITS-1:0]  pwdata;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;
    logic                      in_valid;
    logic                      in_ready;
    logic [DEF_COORD_BITS-1:0] center_x;
    logic [DEF_COORD_BITS-1:0] center_y;
    logic [RAD_IN_BITS-1:0]    radius;
    logic                      out_valid;
    logic                      out_ready;
    logic [DEF_ADDR_BITS-1:0]  addr_px_py;
    logic [DEF_ADDR_BITS-1:0]  addr_py_px;
    logic [DEF_ADDR_BITS-1:0]  addr_ny_px;
    logic [DEF_ADDR_BITS-1:0]  addr_nx_py;
    logic [DEF_ADDR_BITS-1:0]  addr_nx_ny;
    logic [DEF_ADDR_BITS-1:0]  addr_ny_nx;
    logic [DEF_ADDR_BITS-1:0]  addr_py_nx;
    logic [DEF_ADDR_BITS-1:0]  addr_px_ny;
    logic [7:0]                outside_mask;
    logic [PIX_BITS-1:0]       pixel_byte;
    logic                      last_step;
    int                        mismatches;
    int                        results_left;

    int send_idle_pct;
    int stall_pct;
    int holdoff_requests;
    int holdoffs_done;
    int cur_width;
    int cur_height;

    circle_octant_rasterizer_top u_top (.*);

    octant_checker u_checker (.*);

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        holdoffs_done = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoffs_done != holdoff_requests)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                holdoffs_done++;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int stride, input int width, input int height,
                             input int pix);
        write_reg(REG_LINE_STRIDE, stride);
        write_reg(REG_IMAGE_WIDTH, width);
        write_reg(REG_IMAGE_HEIGHT, height);
        write_reg(REG_PIXEL_VALUE, pix);
        cur_width  = width;
        cur_height = height;
    endtask

    // Offer one circle request; hold valid until the beat is taken
    task automatic send_circle(input int cx, input int cy, input int r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        center_x <= cx[DEF_COORD_BITS-1:0];
        center_y <= cy[DEF_COORD_BITS-1:0];
        radius   <= r[RAD_IN_BITS-1:0];
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_random_circle;
        int cx;
        int cy;
        int r;
        case ($urandom_range(3))
            0:
            begin
                cx = $urandom_range(4095);
                cy = $urandom_range(4095);
            end
            1:
            begin
                cx = $urandom_range(64);
                cy = $urandom_range(64);
            end
            default:
            begin
                // straddle the right and bottom image edges
                cx = $urandom_range((cur_width + 64 > 4095) ? 4095 : cur_width + 64);
                cy = $urandom_range((cur_height + 64 > 4095) ? 4095 : cur_height + 64);
            end
        endcase
        case ($urandom_range(9))
            0:       r = 0;
            1:       r = $urandom_range(127, 65);
            2, 3, 4: r = $urandom_range(64, 21);
            default: r = $urandom_range(20, 1);
        endcase
        send_circle(cx, cy, r);
    endtask

    // Drop valid and hold off until every predicted beat has come back
    task automatic wait_for_results;
        in_valid <= 1'b0;
        do @(posedge clk); while (results_left != 0);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        in_valid <= 1'b0;
        center_x <= '0;
        center_y <= '0;
        radius   <= '0;
        send_idle_pct    = 0;
        stall_pct        = 0;
        holdoff_requests = 0;
        cur_width        = RST_IMAGE_WIDTH;
        cur_height       = RST_IMAGE_HEIGHT;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests at the reset configuration
        send_circle(0, 0, 0);
        send_circle(0, 0, 1);
        send_circle(200, 150, 1);
        send_circle(200, 150, 2);
        send_circle(200, 150, 3);
        send_circle(200, 150, 64);
        send_circle(0, 0, 64);
        send_circle(4095, 4095, 127);
        send_circle(399, 299, 10);
        send_circle(400, 300, 10);
        send_circle(4095, 0, 5);
        send_circle(0, 4095, 5);
        send_circle(100, 100, 65);
        send_circle(10, 10, 0);
        send_circle(10, 10, 0);
        send_circle(12'hAAA, 12'h555, 7'h2A);
        send_circle(12'h555, 12'hAAA, 7'h55);
        send_circle(390, 290, 20);
        send_circle(5, 150, 30);
        wait_for_results;

        // long receiver hold-off while requests keep coming
        holdoff_requests++;
        repeat (12) send_circle($urandom_range(399), $urandom_range(299), $urandom_range(30, 5));
        wait_for_results;

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: configure(4, 1, 1, 0);
                1: configure(16384, 4096, 4096, 255);
                2: configure($urandom_range(16384, 4), $urandom_range(4096, 1),
                             $urandom_range(4096, 1), $urandom_range(255));
                3: configure(1600, 400, 300, 8'h5A);
                4: configure($urandom_range(2048, 4), $urandom_range(512, 16),
                             $urandom_range(512, 16), $urandom_range(255));
                default: configure(16384, 4096, 1, 8'hA5);
            endcase
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 86;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 86;
                end
                default:
                begin
                    send_idle_pct = 37;
                    stall_pct     = 37;
                end
            endcase
            repeat (58) send_random_circle;
            wait_for_results;
        end

        repeat (50) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // Run limit
    initial
    begin
        #24000000;
        $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/cor_pkg.sv
rtl/cor_cfg_regs.sv
rtl/cor_ctrl.sv
rtl/cor_datapath.sv
rtl/circle_octant_rasterizer_top.sv
dv/octant_checker.sv
dv/tb.sv
